[rtl/gf256_vandermonde_parity_encoder_macros.svh]
// assertion macros for the gf256 vandermonde parity encoder
// expects clk and rst_n in the scope of the module that uses them
`ifndef GF256_VANDERMONDE_PARITY_ENCODER_MACROS_SVH
`define GF256_VANDERMONDE_PARITY_ENCODER_MACROS_SVH

// same-cycle implication
`define GFVP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GFVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gfvp_pkg.sv]
// shared types, constants and gf(2^8) multiply for the parity encoder
// no dependencies
package gfvp_pkg;

  localparam int BYTE_W = 8;
  localparam int ROW_W  = 3;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;
  localparam int DS_W = 5;
  localparam int PS_W = 4;

  localparam int DEF_MAX_DATA_SHARDS   = 16;
  localparam int DEF_MAX_PARITY_SHARDS = 8;
  localparam int RESULT_LIMIT = 8;
  localparam int CNT_W = $clog2(RESULT_LIMIT + 1);

  localparam logic [8:0] GF_POLY = 9'h11d;

  localparam logic [DS_W-1:0] RST_DATA_SHARDS   = 5'd5;
  localparam logic [PS_W-1:0] RST_PARITY_SHARDS = 4'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DATA_SHARDS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_SHARDS = 4'd1;

  typedef struct packed {
    logic step;
    logic load;
    logic shift;
  } cell_ctrl_t;

  function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                               input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] x;
    logic [BYTE_W-1:0] r;
    x = a;
    r = '0;
    for (int i = 0; i < BYTE_W; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      x = {x[BYTE_W-2:0], 1'b0} ^ (x[BYTE_W-1] ? GF_POLY[BYTE_W-1:0] : '0);
    end
    return r;
  endfunction

endpackage

[rtl/gfvp_channels.sv]
// valid/ready channel interfaces: data in, parity out, register write
// depends on gfvp_pkg
interface gfvp_in_if;
  logic                          valid;
  logic                          ready;
  logic [gfvp_pkg::BYTE_W-1:0]   data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface gfvp_out_if;
  logic                          valid;
  logic                          ready;
  logic [gfvp_pkg::BYTE_W-1:0]   parity_byte;
  logic [gfvp_pkg::ROW_W-1:0]    parity_row;
  logic                          last_of_column;
  modport source (output valid, output parity_byte, output parity_row,
                  output last_of_column, input ready);
  modport sink   (input valid, input parity_byte, input parity_row,
                  input last_of_column, output ready);
endinterface

interface gfvp_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [gfvp_pkg::CFG_IDX_W-1:0]  index;
  logic [gfvp_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/gfvp_cell.sv]
// one parity row: accumulator, running power and one output shift slot
// depends on gfvp_pkg
module gfvp_cell #(
  parameter int ROW = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gfvp_pkg::cell_ctrl_t         ctrl,
  input  logic [gfvp_pkg::BYTE_W-1:0]  data_byte,
  input  logic [gfvp_pkg::BYTE_W-1:0]  dshard_cnt,
  input  logic [gfvp_pkg::BYTE_W-1:0]  slot_in,
  output logic [gfvp_pkg::BYTE_W-1:0]  slot_out
);
  import gfvp_pkg::*;

  logic [BYTE_W-1:0] acc_r, acc_nxt;
  logic [BYTE_W-1:0] pow_r, pow_nxt;
  logic [BYTE_W-1:0] slot_r;
  logic [BYTE_W-1:0] base;
  logic [BYTE_W-1:0] acc_sum;

  assign base    = dshard_cnt + BYTE_W'(ROW + 1);
  assign acc_sum = acc_r ^ gf_mul(data_byte, pow_r);

  always_comb begin
    acc_nxt = acc_r;
    pow_nxt = pow_r;
    if (ctrl.step) begin
      if (ctrl.load) begin
        acc_nxt = '0;
        pow_nxt = BYTE_W'(1);
      end else begin
        acc_nxt = acc_sum;
        pow_nxt = gf_mul(pow_r, base);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      pow_r <= BYTE_W'(1);
    end else begin
      acc_r <= acc_nxt;
      pow_r <= pow_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      slot_r <= acc_sum;
    end else if (ctrl.shift) begin
      slot_r <= slot_in;
    end
  end

  assign slot_out = slot_r;

endmodule

[rtl/gf256_vandermonde_parity_encoder.sv]
// gf(2^8) vandermonde parity encoder, top level: register file, column control
// depends on gfvp_pkg, gfvp_channels, gfvp_cell and the assertion macro header
//
// in_ch takes data bytes column by column, data shard 0 first; one byte per
// transaction, one transaction per cycle except that a closing byte waits
// while the previous column is still draining. every byte updates all parity
// rows at once in a row of cells, each holding one row's accumulator and power.
// the byte that completes a column copies the row sums into the output shift
// slots; out_ch then gives P transactions, row 0 first, last_of_column on
// row P-1, first one the cycle after the closing byte. slots shift one cell
// toward the output per accepted transaction.
// when out_ch stalls, the current parity transaction holds and bytes that do
// not close a column keep flowing in.
// cfg_ch writes the data shard count (index 0) and the parity shard count
// (index 1); it is always ready. the user must write it only while no parity
// is pending; the block itself does not enforce this.
// reset (rst_n low, synchronous) gives D = 5, P = 2, clears all rows.
`include "gf256_vandermonde_parity_encoder_macros.svh"

module gf256_vandermonde_parity_encoder #(
  parameter int MAX_DATA_SHARDS   = gfvp_pkg::DEF_MAX_DATA_SHARDS,
  parameter int MAX_PARITY_SHARDS = gfvp_pkg::DEF_MAX_PARITY_SHARDS
) (
  input  logic          clk,
  input  logic          rst_n,
  gfvp_in_if.sink       in_ch,
  gfvp_out_if.source    out_ch,
  gfvp_cfg_if.sink      cfg_ch
);
  import gfvp_pkg::*;

  localparam int NUM_CELLS = (MAX_PARITY_SHARDS < RESULT_LIMIT) ?
                             MAX_PARITY_SHARDS : RESULT_LIMIT;
  localparam int POS_W = $clog2(MAX_DATA_SHARDS + 1);

  logic [DS_W-1:0]   dshard_cnt_r;
  logic [PS_W-1:0]   pshard_cnt_r;
  logic [POS_W-1:0]  d_eff;
  logic [CNT_W-1:0]  p_eff;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  np_r, np_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              col_end;
  logic              in_fire;
  logic              out_fire;
  logic              load;
  cell_ctrl_t        ctrl;
  logic [BYTE_W-1:0] slot [NUM_CELLS];

  // register writes
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dshard_cnt_r <= RST_DATA_SHARDS;
      pshard_cnt_r <= RST_PARITY_SHARDS;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_DATA_SHARDS:   dshard_cnt_r <= cfg_ch.data[DS_W-1:0];
        REG_PARITY_SHARDS: pshard_cnt_r <= cfg_ch.data[PS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective shard counts
  always_comb begin
    if (dshard_cnt_r == '0) begin
      d_eff = POS_W'(1);
    end else if (int'(dshard_cnt_r) > MAX_DATA_SHARDS) begin
      d_eff = POS_W'(MAX_DATA_SHARDS);
    end else begin
      d_eff = POS_W'(dshard_cnt_r);
    end
  end

  always_comb begin
    if (pshard_cnt_r == '0) begin
      p_eff = CNT_W'(1);
    end else if (int'(pshard_cnt_r) > NUM_CELLS) begin
      p_eff = CNT_W'(NUM_CELLS);
    end else begin
      p_eff = CNT_W'(pshard_cnt_r);
    end
  end

  // column control
  assign col_end  = ({1'b0, pos_r} + 1'b1) >= {1'b0, d_eff};
  assign in_ch.ready = (cnt_r == '0) || !col_end ||
                       ((cnt_r == CNT_W'(1)) && out_ch.ready);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign load     = in_fire && col_end;

  assign ctrl.step  = in_fire;
  assign ctrl.load  = load;
  assign ctrl.shift = out_fire;

  always_comb begin
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    np_nxt      = np_r;
    out_row_nxt = out_row_r;
    if (in_fire) begin
      pos_nxt = col_end ? '0 : POS_W'(pos_r + 1'b1);
    end
    if (load) begin
      cnt_nxt     = p_eff;
      np_nxt      = p_eff;
      out_row_nxt = '0;
    end else if (out_fire) begin
      cnt_nxt     = CNT_W'(cnt_r - 1'b1);
      out_row_nxt = ROW_W'(out_row_r + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      cnt_r     <= '0;
      np_r      <= '0;
      out_row_r <= '0;
    end else begin
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      np_r      <= np_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // row cells, output slots shift toward cell 0
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic [BYTE_W-1:0] slot_in;
    if (i == NUM_CELLS - 1) begin : g_tail
      assign slot_in = '0;
    end else begin : g_link
      assign slot_in = slot[i+1];
    end
    gfvp_cell #(
      .ROW (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .data_byte  (in_ch.data_byte),
      .dshard_cnt (BYTE_W'(d_eff)),
      .slot_in    (slot_in),
      .slot_out   (slot[i])
    );
  end

  assign out_ch.valid          = (cnt_r != '0);
  assign out_ch.parity_byte    = slot[0];
  assign out_ch.parity_row     = out_row_r;
  assign out_ch.last_of_column = (CNT_W'(out_row_r) + 1'b1) == np_r;

  // checks
  `GFVP_ASSERT_SAME(a_close_only_when_free,
    load, (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_fire),
    "column closed while previous parity still pending")
  `GFVP_ASSERT_NEXT(a_load_count,
    load, (cnt_r == $past(p_eff)) && (out_row_r == '0),
    "parity count not loaded at column end")
  `GFVP_ASSERT_NEXT(a_row_advance,
    out_fire && !load && (cnt_r > CNT_W'(1)),
    out_row_r == ROW_W'($past(out_row_r) + 1'b1),
    "parity row did not advance")
  `GFVP_ASSERT_SAME(a_last_matches_count,
    out_ch.valid, out_ch.last_of_column == (cnt_r == CNT_W'(1)),
    "last flag disagrees with remaining count")

endmodule

[tb/testbench.sv]
// self-checking testbench for gf256_vandermonde_parity_encoder
// depends on gfvp_pkg, the gfvp channel interfaces and the encoder rtl
// runs a directed stimulus table, then random columns, against a gf(2^8) parity predictor
`timescale 1ns / 100ps

module testbench;
  import gfvp_pkg::*;

  localparam int RANDOM_ITEMS  = 72;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 80;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'hf;
  localparam logic [BYTE_W-1:0] FIELD_POLY_LOW = 8'h1d;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;
  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_ALTERNATE} sink_mode_t;

  typedef struct packed {
    row_kind_t              kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  value;
    logic                   typed;
    logic [BYTE_W-1:0]      parity;
  } stim_row_t;

  typedef struct packed {
    logic [BYTE_W-1:0] parity;
    logic [ROW_W-1:0]  row;
    logic              last;
  } parity_rec_t;

  localparam int DIRECTED_ROWS = 38;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // reset settings, five data shards and two parity shards
    '{ROW_BYTE, 4'h0, 8'hff, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h00, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h80, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h7f, 1'b0, 8'h00},
    // one data shard: every row is the byte itself
    '{ROW_REG, REG_DATA_SHARDS, 8'h01, 1'b0, 8'h00},
    '{ROW_REG, REG_PARITY_SHARDS, 8'h08, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hff, 1'b1, 8'hff},
    '{ROW_BYTE, 4'h0, 8'h00, 1'b1, 8'h00},
    // zero shard counts, upper data bits set
    '{ROW_REG, REG_DATA_SHARDS, 8'he0, 1'b0, 8'h00},
    '{ROW_REG, REG_PARITY_SHARDS, 8'hf0, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'ha5, 1'b1, 8'ha5},
    '{ROW_REG, REG_UNMAPPED, 8'h03, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h3c, 1'b1, 8'h3c},
    // shard count shrinks mid-column
    '{ROW_REG, REG_DATA_SHARDS, 8'h04, 1'b0, 8'h00},
    '{ROW_REG, REG_PARITY_SHARDS, 8'h03, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h12, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h34, 1'b0, 8'h00},
    '{ROW_REG, REG_DATA_SHARDS, 8'h02, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h56, 1'b0, 8'h00},
    // counts above the maximum saturate
    '{ROW_REG, REG_DATA_SHARDS, 8'h1f, 1'b0, 8'h00},
    '{ROW_REG, REG_PARITY_SHARDS, 8'h0f, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h01, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h02, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h04, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h08, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h10, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h20, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h40, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h80, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hfe, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hfd, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hfb, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hf7, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hef, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hdf, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'hbf, 1'b0, 8'h00},
    '{ROW_BYTE, 4'h0, 8'h7f, 1'b0, 8'h00}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  gfvp_in_if  in_if ();
  gfvp_out_if out_if ();
  gfvp_cfg_if cfg_if ();

  gf256_vandermonde_parity_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [DS_W-1:0]   shards_data   = RST_DATA_SHARDS;
  logic [PS_W-1:0]   shards_parity = RST_PARITY_SHARDS;
  logic [BYTE_W-1:0] row_sum [DEF_MAX_PARITY_SHARDS] = '{default: 8'h00};
  logic [BYTE_W-1:0] row_pow [DEF_MAX_PARITY_SHARDS] = '{default: 8'h01};
  int                column_fill = 0;
  parity_rec_t       parity_due [$];

  logic              typed_known = 1'b0;
  logic [BYTE_W-1:0] typed_parity = '0;
  int                errors = 0;
  int                burst_left = 0;
  bit                steady = 1'b0;
  bit                hold_wanted = 1'b0;
  bit                hold_done = 1'b0;

  function automatic logic [BYTE_W-1:0] gf_product(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] acc;
    acc = '0;
    for (int i = BYTE_W - 1; i >= 0; i--) begin
      acc = {acc[BYTE_W-2:0], 1'b0} ^ (acc[BYTE_W-1] ? FIELD_POLY_LOW : 8'h00);
      if (b[i]) begin
        acc = acc ^ a;
      end
    end
    return acc;
  endfunction

  always @(posedge clk) begin : monitor
    int d;
    int np;
    logic [BYTE_W-1:0] base;
    parity_rec_t want;
    parity_rec_t got;
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_DATA_SHARDS) begin
          shards_data = cfg_if.data[DS_W-1:0];
        end else if (cfg_if.index == REG_PARITY_SHARDS) begin
          shards_parity = cfg_if.data[PS_W-1:0];
        end
      end
      if (in_if.valid && in_if.ready) begin
        d = (shards_data == 0) ? 1 : int'(shards_data);
        if (d > DEF_MAX_DATA_SHARDS) begin
          d = DEF_MAX_DATA_SHARDS;
        end
        for (int p = 0; p < DEF_MAX_PARITY_SHARDS; p++) begin
          base = 8'(d + p + 1);
          row_sum[p] = row_sum[p] ^ gf_product(in_if.data_byte, row_pow[p]);
          row_pow[p] = gf_product(row_pow[p], base);
        end
        column_fill++;
        if (column_fill >= d) begin
          np = (shards_parity == 0) ? 1 : int'(shards_parity);
          if (np > DEF_MAX_PARITY_SHARDS) begin
            np = DEF_MAX_PARITY_SHARDS;
          end
          if (np > RESULT_LIMIT) begin
            np = RESULT_LIMIT;
          end
          for (int p = 0; p < np; p++) begin
            want.parity = typed_known ? typed_parity : row_sum[p];
            want.row    = ROW_W'(p);
            want.last   = (p == np - 1);
            parity_due.push_back(want);
          end
          for (int p = 0; p < DEF_MAX_PARITY_SHARDS; p++) begin
            row_sum[p] = 8'h00;
            row_pow[p] = 8'h01;
          end
          column_fill = 0;
        end
      end
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.parity_byte, out_if.parity_row, out_if.last_of_column};
        if (parity_due.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected parity transaction: byte %02h row %0d last %0b",
                     got.parity, got.row, got.last);
          end
        end else begin
          want = parity_due.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("parity mismatch: expected byte %02h row %0d last %0b, got %02h %0d %0b",
                       want.parity, want.row, want.last, got.parity, got.row, got.last);
            end
          end
        end
      end
    end
  end

  task automatic offer_byte(input logic [BYTE_W-1:0] b, input logic known,
                            input logic [BYTE_W-1:0] tp);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      if (!steady) begin
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
          @(negedge clk);
          in_if.valid = 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    @(negedge clk);
    in_if.valid     = 1'b1;
    in_if.data_byte = b;
    typed_known     = known;
    typed_parity    = tp;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic drain_and_settle();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (parity_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  initial begin : stimulus
    logic [DS_W-1:0]   ds_pick;
    logic [PS_W-1:0]   ps_pick;
    logic [BYTE_W-1:0] b;
    logic [7:0]        rnd;
    int                eff_d;
    int                n_bytes;
    int                random_sent;
    bit                first;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = '0;
    cfg_if.data     = '0;
    random_sent     = 0;
    first           = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (DIRECTED[r].kind == ROW_REG) begin
        drain_and_settle();
        write_reg(DIRECTED[r].index, DIRECTED[r].value);
      end else begin
        offer_byte(DIRECTED[r].value, DIRECTED[r].typed, DIRECTED[r].parity);
      end
    end

    while (random_sent < RANDOM_ITEMS) begin
      if (first) begin
        ds_pick = 5'd1;
        ps_pick = 4'd8;
      end else begin
        case ($urandom_range(0, 9))
          0: ds_pick = 5'd0;
          1: ds_pick = 5'd16;
          2: ds_pick = 5'd31;
          3: ds_pick = DS_W'($urandom_range(17, 30));
          default: ds_pick = DS_W'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 7))
          0: ps_pick = 4'd0;
          1: ps_pick = 4'd8;
          2: ps_pick = 4'd15;
          3: ps_pick = PS_W'($urandom_range(9, 14));
          default: ps_pick = PS_W'($urandom_range(1, 7));
        endcase
      end
      drain_and_settle();
      rnd = $urandom;
      write_reg(REG_DATA_SHARDS, {rnd[7:5], ds_pick});
      rnd = $urandom;
      write_reg(REG_PARITY_SHARDS, {rnd[7:4], ps_pick});
      eff_d = (ds_pick == 0) ? 1 : (ds_pick > DEF_MAX_DATA_SHARDS) ? DEF_MAX_DATA_SHARDS
                                                                   : int'(ds_pick);
      n_bytes = eff_d * ((eff_d >= 8) ? 1 : $urandom_range(1, 3));
      // sometimes add a partial column so the next setting can land mid-column
      if ($urandom_range(0, 3) == 0) begin
        n_bytes += $urandom_range(0, eff_d - 1);
      end
      steady = first || ($urandom_range(0, 3) == 0);
      if (first) begin
        n_bytes     = 12;
        hold_wanted = 1'b1;
      end
      repeat (n_bytes) begin
        b = $urandom;
        case ($urandom_range(0, 15))
          0: b = 8'h00;
          1: b = 8'hff;
          default: ;
        endcase
        offer_byte(b, 1'b0, 8'h00);
        random_sent++;
      end
      first = 1'b0;
    end

    drain_and_settle();
    if (errors == 0 && parity_due.size() == 0) begin
      $display("PASS gf256_vandermonde_parity_encoder");
    end else begin
      $display("FAIL gf256_vandermonde_parity_encoder");
    end
    $finish;
  end

  initial begin : receiver
    sink_mode_t mode;
    int len;
    out_if.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_wanted && !hold_done) begin
        // long hold-off while the sender keeps going
        @(negedge clk);
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        mode = sink_mode_t'($urandom_range(0, 3));
        len  = $urandom_range(8, 40);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            SINK_OPEN:      out_if.ready = 1'b1;
            SINK_COIN:      out_if.ready = 1'($urandom_range(0, 1));
            SINK_SPARSE:    out_if.ready = ($urandom_range(0, 3) == 0);
            SINK_ALTERNATE: out_if.ready = ~out_if.ready;
            default:        out_if.ready = 1'b1;
          endcase
        end
      end
    end
  end

  initial begin : watchdog
    #200000;
    $display("FAIL gf256_vandermonde_parity_encoder");
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/gfvp_pkg.sv
rtl/gfvp_channels.sv
rtl/gfvp_cell.sv
rtl/gf256_vandermonde_parity_encoder.sv
tb/testbench.sv
